@@ rtl/kclw_pkg.sv @@
// Shared types, codes and nibble scripts for the keypad-to-LCD nibble writer.
`timescale 1ns / 1ps
package kclw_pkg;

	typedef logic [1:0] kclw_action_t;
	typedef logic [1:0] kclw_prefix_t;

	localparam kclw_action_t ACT_INIT    = 2'd0;
	localparam kclw_action_t ACT_KEY     = 2'd1;
	localparam kclw_action_t ACT_RAW_CMD = 2'd2;
	localparam kclw_action_t ACT_RAW_CHR = 2'd3;

	// command run sent ahead of the byte
	localparam kclw_prefix_t PFX_NONE       = 2'd0;
	localparam kclw_prefix_t PFX_INIT       = 2'd1;
	localparam kclw_prefix_t PFX_LINE2      = 2'd2;
	localparam kclw_prefix_t PFX_CLEAR_HOME = 2'd3;

	localparam logic       RS_CMD       = 1'b0;
	localparam logic       RS_DATA      = 1'b1;
	localparam logic [7:0] CMD_FUNC8    = 8'h30;
	localparam logic [7:0] CMD_FUNC4    = 8'h20;
	localparam logic [5:0] SCREEN_CHARS = 6'd32;

	localparam int INIT_NIBS_N = 18;
	localparam int NIB_IDX_W   = 5;

	localparam logic [3:0] INIT_NIBS [0:INIT_NIBS_N-1] = '{
		4'h3, 4'h3, 4'h3, 4'h2,
		4'h2, 4'h8, 4'h0, 4'hC, 4'h0, 4'h1, 4'h8, 4'h0, 4'h0, 4'h6,
		4'h0, 4'h1, 4'h8, 4'h0
	};
	localparam logic [3:0] CLEAR_HOME_NIBS [0:3] = '{4'h0, 4'h1, 4'h8, 4'h0};
	localparam logic [3:0] LINE2_NIBS [0:1] = '{4'hC, 4'h0};

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	typedef struct packed {
		kclw_prefix_t prefix;
		logic         has_byte;
		logic         rs;
		logic [7:0]   data;
	} kclw_job_t;

	function automatic logic [NIB_IDX_W-1:0] prefix_len(input kclw_prefix_t p);
		logic [NIB_IDX_W-1:0] n;
		unique case (p)
			PFX_INIT:       n = NIB_IDX_W'(INIT_NIBS_N);
			PFX_LINE2:      n = NIB_IDX_W'(2);
			PFX_CLEAR_HOME: n = NIB_IDX_W'(4);
			default:        n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] prefix_nibble(input kclw_prefix_t p,
			input logic [NIB_IDX_W-1:0] idx);
		logic [3:0] v;
		unique case (p)
			PFX_INIT:       v = (idx < NIB_IDX_W'(INIT_NIBS_N)) ? INIT_NIBS[idx] : 4'h0;
			PFX_LINE2:      v = LINE2_NIBS[idx[0]];
			PFX_CLEAR_HOME: v = CLEAR_HOME_NIBS[idx[1:0]];
			default:        v = 4'h0;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h41 + {4'h0, v} - 8'd10);
	endfunction

endpackage

@@ rtl/kclw_if.sv @@
// Valid/ready channel interfaces for keypad items and LCD nibbles.
`timescale 1ns / 1ps
interface kclw_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] scan_row;
	logic [3:0] column_lines;
	logic [7:0] raw_byte;

	modport source (output valid, action, scan_row, column_lines, raw_byte, input ready);
	modport sink (input valid, action, scan_row, column_lines, raw_byte, output ready);
endinterface

interface kclw_nib_if;
	logic       valid;
	logic       ready;
	logic [3:0] nibble;
	logic       register_select;
	logic       last;

	modport source (output valid, nibble, register_select, last, input ready);
	modport sink (input valid, nibble, register_select, last, output ready);
endinterface

@@ rtl/kclw_front.sv @@
// Front end: accepts items, tracks cursor and column, builds nibble jobs.
`timescale 1ns / 1ps
module kclw_front
	import kclw_pkg::*;
#(
	parameter int LINE_LENGTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	kclw_item_if.sink       item,
	input  logic            q_full,
	output logic            push,
	output kclw_job_t       job
);

	logic [5:0] cursor_q;
	logic [1:0] held_col_q;
	logic [1:0] col_next;
	logic [5:0] cursor_next;
	logic       take;

	assign item.ready = !q_full;
	assign take = item.valid && !q_full;

	always_comb begin
		unique case (item.column_lines)
			4'b0001: col_next = 2'd0;
			4'b0010: col_next = 2'd1;
			4'b0100: col_next = 2'd2;
			4'b1000: col_next = 2'd3;
			default: col_next = held_col_q;
		endcase
	end

	always_comb begin
		job = '{prefix: PFX_NONE, has_byte: 1'b1, rs: RS_DATA, data: item.raw_byte};
		push = 1'b0;
		cursor_next = cursor_q;
		unique case (item.action)
			ACT_INIT: begin
				job.prefix = PFX_INIT;
				job.has_byte = 1'b0;
				job.rs = RS_CMD;
				push = take;
				cursor_next = '0;
			end
			ACT_KEY: begin
				job.data = hex_char({item.scan_row, col_next});
				push = take && (item.column_lines != 4'h0);
				if (cursor_q == 6'(LINE_LENGTH)) begin
					job.prefix = PFX_LINE2;
					cursor_next = cursor_q + 6'd1;
				end else if (cursor_q == SCREEN_CHARS) begin
					job.prefix = PFX_CLEAR_HOME;
					cursor_next = 6'd1;
				end else begin
					cursor_next = cursor_q + 6'd1;
				end
			end
			ACT_RAW_CMD: begin
				job.rs = RS_CMD;
				push = take;
			end
			default: push = take;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			held_col_q <= '0;
		end else if (push) begin
			cursor_q <= cursor_next;
			if (item.action == ACT_KEY) begin
				held_col_q <= col_next;
			end
		end
	end

endmodule

@@ rtl/kclw_fifo.sv @@
// Short job queue between the front end and the nibble sequencer.
`timescale 1ns / 1ps
module kclw_fifo
	import kclw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  kclw_job_t wr_job,
	output logic      full,
	input  logic      pop,
	output logic      rd_valid,
	output kclw_job_t rd_job
);

	kclw_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign full = (count_q == (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/kclw_back.sv @@
// Back end: walks each job nibble by nibble into the output register.
`timescale 1ns / 1ps
module kclw_back
	import kclw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  kclw_job_t  job,
	output logic       pop,
	kclw_nib_if.source result
);

	logic [NIB_IDX_W-1:0] idx_q;
	logic [NIB_IDX_W-1:0] plen;
	logic [NIB_IDX_W-1:0] total;
	logic [1:0]           byte_nibs;
	logic                 short_cmd;
	logic                 load;
	logic                 is_last;
	logic [3:0]           nib;
	logic                 rs;
	logic                 valid_q;
	logic [3:0]           nibble_q;
	logic                 rs_q;
	logic                 last_q;

	assign plen = prefix_len(job.prefix);
	// 8-bit-mode and 4-bit-mode function sets only have a high nibble
	assign short_cmd = (job.rs == RS_CMD) && ((job.data == CMD_FUNC8) || (job.data == CMD_FUNC4));
	assign byte_nibs = !job.has_byte ? 2'd0 : (short_cmd ? 2'd1 : 2'd2);
	assign total = plen + NIB_IDX_W'(byte_nibs);
	assign is_last = (idx_q == total - NIB_IDX_W'(1));
	assign load = job_valid && (!valid_q || result.ready);
	assign pop = load && is_last;

	always_comb begin
		if (idx_q < plen) begin
			nib = prefix_nibble(job.prefix, idx_q);
			rs = RS_CMD;
		end else if (idx_q == plen) begin
			nib = job.data[7:4];
			rs = job.rs;
		end else begin
			nib = job.data[3:0];
			rs = job.rs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? '0 : idx_q + NIB_IDX_W'(1);
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nibble_q <= nib;
			rs_q <= rs;
			last_q <= is_last;
		end
	end

	assign result.valid = valid_q;
	assign result.nibble = nibble_q;
	assign result.register_select = rs_q;
	assign result.last = last_q;

endmodule

@@ rtl/keypad_to_char_lcd_nibble_writer_unit.sv @@
// Top level of the keypad-to-character-LCD 4-bit nibble writer.
`timescale 1ns / 1ps
// Turns init, keypad, raw command and raw character items into the nibble
// transfers of a 4-bit character LCD bus, high nibble first, each tagged
// command or data, with last set on the final nibble of an item. The output
// carries one nibble per cycle while the receiver is ready. An item makes 1
// nibble for a single-nibble command, 2 for a plain byte, up to 6 for a key
// at a line or screen boundary, and 18 for init, all emitted by the back-end
// sequencer. A keypad sample with no column line set is taken and produces
// nothing. Items are taken while the two-entry job queue has room, so new
// items keep arriving while earlier nibbles still wait at the output.
module keypad_to_char_lcd_nibble_writer_unit
	import kclw_pkg::*;
#(
	parameter int LINE_LENGTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	kclw_item_if.sink  item,
	kclw_nib_if.source result
);

	logic      push;
	logic      q_full;
	logic      pop;
	logic      head_valid;
	kclw_job_t new_job;
	kclw_job_t head_job;

	kclw_front #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.push   (push),
		.job    (new_job)
	);

	kclw_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (new_job),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (head_valid),
		.rd_job   (head_job)
	);

	kclw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ rtl/kclw_checker.sv @@
// Port-level checks for the nibble writer, bound to its top level.
`timescale 1ns / 1ps
module kclw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [3:0] res_nibble,
	input logic       res_rs,
	input logic       res_last
);

	// a stalled nibble holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_nibble)
			&& $stable(res_rs) && $stable(res_last))
		else $error("stalled result changed");

	// data bytes always go out as two back-to-back nibbles, the second one last
	a_data_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_rs && !res_last |=> res_valid && res_rs && res_last)
		else $error("data high nibble not followed by its low nibble");

	// the input only backs up when output work is pending
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> res_valid)
		else $error("input stalled with no result pending");

endmodule

bind keypad_to_char_lcd_nibble_writer_unit kclw_checker u_kclw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_nibble (result.nibble),
	.res_rs     (result.register_select),
	.res_last   (result.last)
);

@@ test/keypad_to_char_lcd_nibble_writer_unit_tb.sv @@
// Self-checking testbench for the keypad-to-character-LCD nibble writer.
`timescale 1ns / 1ps
module keypad_to_char_lcd_nibble_writer_unit_tb;
	import kclw_pkg::*;

	localparam int LINE_LEN       = 16;
	localparam int N_RANDOM       = 300;
	localparam int HOLD_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;
	localparam int MAX_REPORTS    = 10;

	localparam logic [7:0] LCD_CLEAR = 8'h01;
	localparam logic [7:0] LCD_HOME  = 8'h80;
	localparam logic [7:0] LCD_LINE2 = 8'hC0;
	localparam logic [7:0] POWER_UP_CMDS [0:8] = '{
		8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h0C, 8'h01, 8'h80, 8'h06
	};

	typedef struct packed {
		kclw_action_t action;
		logic [1:0]   scan_row;
		logic [3:0]   column_lines;
		logic [7:0]   raw_byte;
	} key_item_t;

	typedef struct packed {
		logic [3:0] nibble;
		logic       rs;
		logic       last;
	} lcd_nib_t;

	// typed rows carry their own expectation, the rest go through the predictor
	typedef struct packed {
		key_item_t stim;
		logic      typed;
		logic [1:0] n_typed;
		lcd_nib_t  exp0;
		lcd_nib_t  exp1;
	} dir_row_t;

	localparam lcd_nib_t NO_NIB = '{4'h0, 1'b0, 1'b0};
	localparam int N_DIRECTED = 20;

	localparam dir_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
		// no key pressed
		'{'{ACT_KEY, 2'd0, 4'h0, 8'h5A}, 1'b1, 2'd0, NO_NIB, NO_NIB},
		// first key after reset: '0'
		'{'{ACT_KEY, 2'd0, 4'h1, 8'hA5}, 1'b1, 2'd2,
			'{4'h3, RS_DATA, 1'b0}, '{4'h0, RS_DATA, 1'b1}},
		// last row, last column: 'F'
		'{'{ACT_KEY, 2'd3, 4'h8, 8'h00}, 1'b1, 2'd2,
			'{4'h4, RS_DATA, 1'b0}, '{4'h6, RS_DATA, 1'b1}},
		// several columns keep the held column
		'{'{ACT_KEY, 2'd2, 4'hF, 8'hFF}, 1'b0, 2'd0, NO_NIB, NO_NIB},
		'{'{ACT_KEY, 2'd1, 4'h6, 8'h00}, 1'b0, 2'd0, NO_NIB, NO_NIB},
		'{'{ACT_KEY, 2'd3, 4'h0, 8'hFF}, 1'b0, 2'd0, NO_NIB, NO_NIB},
		// short commands send their high nibble only, other commands both nibbles
		'{'{ACT_RAW_CMD, 2'd0, 4'h0, 8'h30}, 1'b1, 2'd1,
			'{4'h3, RS_CMD, 1'b1}, NO_NIB},
		'{'{ACT_RAW_CMD, 2'd3, 4'hF, 8'h20}, 1'b1, 2'd1,
			'{4'h2, RS_CMD, 1'b1}, NO_NIB},
		'{'{ACT_RAW_CMD, 2'd0, 4'h0, 8'h00}, 1'b1, 2'd2,
			'{4'h0, RS_CMD, 1'b0}, '{4'h0, RS_CMD, 1'b1}},
		'{'{ACT_RAW_CMD, 2'd3, 4'hF, 8'hFF}, 1'b1, 2'd2,
			'{4'hF, RS_CMD, 1'b0}, '{4'hF, RS_CMD, 1'b1}},
		// same bytes as data go out whole
		'{'{ACT_RAW_CHR, 2'd1, 4'h2, 8'h30}, 1'b1, 2'd2,
			'{4'h3, RS_DATA, 1'b0}, '{4'h0, RS_DATA, 1'b1}},
		'{'{ACT_RAW_CHR, 2'd2, 4'h4, 8'h20}, 1'b1, 2'd2,
			'{4'h2, RS_DATA, 1'b0}, '{4'h0, RS_DATA, 1'b1}},
		'{'{ACT_RAW_CHR, 2'd3, 4'hF, 8'hFF}, 1'b1, 2'd2,
			'{4'hF, RS_DATA, 1'b0}, '{4'hF, RS_DATA, 1'b1}},
		'{'{ACT_RAW_CHR, 2'd0, 4'h0, 8'h00}, 1'b1, 2'd2,
			'{4'h0, RS_DATA, 1'b0}, '{4'h0, RS_DATA, 1'b1}},
		'{'{ACT_RAW_CMD, 2'd2, 4'h9, 8'h28}, 1'b0, 2'd0, NO_NIB, NO_NIB},
		'{'{ACT_INIT, 2'd0, 4'h0, 8'h00}, 1'b0, 2'd0, NO_NIB, NO_NIB},
		'{'{ACT_KEY, 2'd2, 4'h4, 8'h3C}, 1'b0, 2'd0, NO_NIB, NO_NIB},
		'{'{ACT_KEY, 2'd1, 4'h2, 8'hC3}, 1'b0, 2'd0, NO_NIB, NO_NIB},
		'{'{ACT_INIT, 2'd3, 4'hF, 8'hFF}, 1'b0, 2'd0, NO_NIB, NO_NIB},
		'{'{ACT_KEY, 2'd0, 4'hC, 8'h81}, 1'b0, 2'd0, NO_NIB, NO_NIB}
	};

	logic clk = 1'b0;
	logic arst_n;

	kclw_item_if item_ch ();
	kclw_nib_if  nib_ch ();

	keypad_to_char_lcd_nibble_writer_unit #(
		.LINE_LENGTH(LINE_LEN)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(nib_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [5:0] lcd_cursor;
	logic [1:0] key_column;
	lcd_nib_t   item_nibbles [$];
	lcd_nib_t   pending_nibbles [$];

	// typed expectation of the item on offer
	logic       cur_typed;
	logic [1:0] cur_n_typed;
	lcd_nib_t   cur_exp0, cur_exp1;

	int  src_idle_pct;
	int  snk_stall_pct;
	logic hold_req;
	int  idle_cycles;
	int  mismatch_count;

	function automatic logic [7:0] key_ascii(input logic [3:0] code);
		return (code < 4'd10) ? 8'h30 + 8'(code) : 8'h37 + 8'(code);
	endfunction

	function automatic void put_lcd_byte(input logic [7:0] b, input logic rs);
		item_nibbles.push_back('{b[7:4], rs, 1'b0});
		if (rs == RS_CMD && (b == CMD_FUNC8 || b == CMD_FUNC4))
			return;
		item_nibbles.push_back('{b[3:0], rs, 1'b0});
	endfunction

	function automatic void predict_nibbles(input key_item_t it);
		item_nibbles.delete();
		case (it.action)
			ACT_INIT: begin
				foreach (POWER_UP_CMDS[i])
					put_lcd_byte(POWER_UP_CMDS[i], RS_CMD);
				put_lcd_byte(LCD_CLEAR, RS_CMD);
				put_lcd_byte(LCD_HOME, RS_CMD);
				lcd_cursor = '0;
			end
			ACT_KEY: begin
				if (it.column_lines != 4'h0) begin
					case (it.column_lines)
						4'b0001: key_column = 2'd0;
						4'b0010: key_column = 2'd1;
						4'b0100: key_column = 2'd2;
						4'b1000: key_column = 2'd3;
						default: ;
					endcase
					if (lcd_cursor == 6'(LINE_LEN)) begin
						put_lcd_byte(LCD_LINE2, RS_CMD);
					end else if (lcd_cursor == SCREEN_CHARS) begin
						put_lcd_byte(LCD_CLEAR, RS_CMD);
						put_lcd_byte(LCD_HOME, RS_CMD);
						lcd_cursor = '0;
					end
					put_lcd_byte(key_ascii({it.scan_row, key_column}), RS_DATA);
					lcd_cursor = lcd_cursor + 6'd1;
				end
			end
			ACT_RAW_CMD: put_lcd_byte(it.raw_byte, RS_CMD);
			default:     put_lcd_byte(it.raw_byte, RS_DATA);
		endcase
		if (item_nibbles.size() > 0)
			item_nibbles[item_nibbles.size()-1].last = 1'b1;
	endfunction

	function automatic void log_mismatch(input string what, input lcd_nib_t want,
			input lcd_nib_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t %s: expected nibble %h rs %b last %b, got nibble %h rs %b last %b",
				$realtime, what, want.nibble, want.rs, want.last,
				got.nibble, got.rs, got.last);
	endfunction

	// monitor: item transfers feed the predictor, nibble transfers are checked
	always @(posedge clk) begin
		key_item_t seen;
		lcd_nib_t  got, want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				seen = '{item_ch.action, item_ch.scan_row, item_ch.column_lines,
					item_ch.raw_byte};
				predict_nibbles(seen);
				if (cur_typed) begin
					if (cur_n_typed > 2'd0)
						pending_nibbles.push_back(cur_exp0);
					if (cur_n_typed > 2'd1)
						pending_nibbles.push_back(cur_exp1);
				end else begin
					foreach (item_nibbles[i])
						pending_nibbles.push_back(item_nibbles[i]);
				end
			end
			if (nib_ch.valid && nib_ch.ready) begin
				got = '{nib_ch.nibble, nib_ch.register_select, nib_ch.last};
				if (pending_nibbles.size() == 0) begin
					log_mismatch("unexpected nibble", NO_NIB, got);
				end else begin
					want = pending_nibbles.pop_front();
					if (got.nibble !== want.nibble || got.rs !== want.rs
							|| got.last !== want.last)
						log_mismatch("nibble mismatch", want, got);
				end
			end
			if ((item_ch.valid && item_ch.ready) || (nib_ch.valid && nib_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("Some tests failed");
		$finish;
	end

	// nibble receiver, with one long hold-off on request
	initial begin
		nib_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				nib_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(negedge clk);
			end
			nib_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic send_item(input key_item_t stim, input logic typed,
			input logic [1:0] n_typed, input lcd_nib_t e0, input lcd_nib_t e1);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.action       <= stim.action;
		item_ch.scan_row     <= stim.scan_row;
		item_ch.column_lines <= stim.column_lines;
		item_ch.raw_byte     <= stim.raw_byte;
		cur_typed   = typed;
		cur_n_typed = n_typed;
		cur_exp0    = e0;
		cur_exp1    = e1;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	initial begin
		key_item_t stim;
		int counted_items;
		int seg, seg_len, pick;
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.action       = ACT_INIT;
		item_ch.scan_row     = '0;
		item_ch.column_lines = '0;
		item_ch.raw_byte     = '0;
		lcd_cursor     = '0;
		key_column     = '0;
		cur_typed      = 1'b0;
		cur_n_typed    = '0;
		cur_exp0       = NO_NIB;
		cur_exp1       = NO_NIB;
		src_idle_pct   = 0;
		snk_stall_pct  = 0;
		hold_req       = 1'b0;
		mismatch_count = 0;
		counted_items  = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIRECTED; r++)
			send_item(DIRECTED_ROWS[r].stim, DIRECTED_ROWS[r].typed,
				DIRECTED_ROWS[r].n_typed, DIRECTED_ROWS[r].exp0, DIRECTED_ROWS[r].exp1);

		// receiver stops while items keep coming, so the job queue backs up
		hold_req = 1'b1;

		while (counted_items < N_RANDOM) begin
			seg = $urandom_range(99);
			seg_len = (seg < 70) ? $urandom_range(40, 10) :
				(seg < 92) ? $urandom_range(6, 2) : 1;
			for (int k = 0; k < seg_len; k++) begin
				case (counted_items * 4 / N_RANDOM)
					0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
					1: begin src_idle_pct = 79; snk_stall_pct = 0;  end
					2: begin src_idle_pct = 0;  snk_stall_pct = 79; end
					default: begin src_idle_pct = 35; snk_stall_pct = 35; end
				endcase
				stim.scan_row     = 2'($urandom);
				stim.column_lines = 4'($urandom);
				stim.raw_byte     = 8'($urandom);
				if (seg < 70) begin
					// key run with the odd character in between
					pick = $urandom_range(99);
					if (pick < 8) begin
						stim.action = ACT_RAW_CHR;
					end else begin
						stim.action = ACT_KEY;
						if (pick < 80)
							stim.column_lines = 4'b0001 << $urandom_range(3);
						else if (pick < 88)
							stim.column_lines = 4'h0;
						else
							while ($countones(stim.column_lines) < 2)
								stim.column_lines = 4'($urandom);
					end
				end else if (seg < 92) begin
					stim.action = $urandom_range(1) ? ACT_RAW_CMD : ACT_RAW_CHR;
					if ($urandom_range(3) == 0)
						stim.raw_byte = $urandom_range(1) ? CMD_FUNC8 : CMD_FUNC4;
				end else begin
					stim.action = ACT_INIT;
				end
				send_item(stim, 1'b0, 2'd0, NO_NIB, NO_NIB);
				if (!(stim.action == ACT_KEY && stim.column_lines == 4'h0))
					counted_items++;
			end
		end
		@(negedge clk);
		item_ch.valid <= 1'b0;
		snk_stall_pct = 0;

		while (pending_nibbles.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_nibbles.size() != 0)
			log_mismatch("missing nibble", pending_nibbles[0], NO_NIB);

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/kclw_pkg.sv
rtl/kclw_if.sv
rtl/kclw_front.sv
rtl/kclw_fifo.sv
rtl/kclw_back.sv
rtl/keypad_to_char_lcd_nibble_writer_unit.sv
rtl/kclw_checker.sv
test/keypad_to_char_lcd_nibble_writer_unit_tb.sv
